FILE: hw/rtl/seven_segment_two_wire_display_driver_defines.svh
// ============================================================================
// Assertion macros for the seven-segment two-wire display driver
// Immediate-style concurrent checks that vanish when SYNTHESIS is defined.
// ============================================================================
`ifndef SEVEN_SEGMENT_TWO_WIRE_DISPLAY_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_TWO_WIRE_DISPLAY_DRIVER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define SSD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssd assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssd assertion failed");
`else
`define SSD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/ssd_pkg.sv
// ============================================================================
// Seven-segment display driver package
// Types, command and phase codes, and the segment tables of the driver.
// ============================================================================
`default_nettype none

package ssd_pkg;

   // Display geometry.
   localparam int DIGIT_COUNT   = 4;
   localparam int DISPLAY_COUNT = 2;
   localparam int WORD_COUNT    = 5;
   localparam int BYTE_COUNT    = 2 + DIGIT_COUNT;
   localparam int LAST_BYTE     = BYTE_COUNT - 1;
   localparam int POS_W         = $clog2(BYTE_COUNT);
   localparam int STEP_W        = $clog2(DIGIT_COUNT);

   typedef logic [7:0] seg_type;

   // Command codes; codes above CMD_BRIGHT behave as a tick.
   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_DECIMAL = 3'd1,
      CMD_TEXT    = 3'd2,
      CMD_CLEAR   = 3'd3,
      CMD_BRIGHT  = 3'd4
   } cmd_type;

   // Line sequencer phases.
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_START    = 4'd1,
      PH_BIT_LOW  = 4'd2,
      PH_BIT_HIGH = 4'd3,
      PH_ACK_LOW  = 4'd4,
      PH_ACK_HIGH = 4'd5,
      PH_STOP_A   = 4'd6,
      PH_STOP_B   = 4'd7,
      PH_STOP_C   = 4'd8
   } phase_type;

   // Protocol bytes.
   localparam seg_type MODE_BYTE   = 8'h40;
   localparam seg_type ADDR_BYTE   = 8'hC0;
   localparam seg_type BRIGHT_BASE = 8'h87;
   localparam seg_type SEP_MASK    = 8'h80;
   localparam logic [3:0] BRIGHT_MAX = 4'd8;
   localparam logic [13:0] VALUE_WRAP = 14'd10000;

   // Hold times of each phase, in microsecond units.
   localparam logic [2:0] WAIT_START = 3'd2;
   localparam logic [2:0] WAIT_BIT   = 3'd3;
   localparam logic [2:0] WAIT_ACK_L = 3'd5;
   localparam logic [2:0] WAIT_SHORT = 3'd2;

   // Segment patterns of the decimal digits.
   localparam seg_type DIGIT_SEGS [10] = '{
      8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
   };

   // Four-letter words: start, time, bonus, bright, blank.
   localparam seg_type WORD_SEGS [WORD_COUNT][DIGIT_COUNT] = '{
      '{8'h6d, 8'h78, 8'h77, 8'h50},
      '{8'h78, 8'h10, 8'h54, 8'h44},
      '{8'h7c, 8'h5c, 8'h54, 8'h1c},
      '{8'h7c, 8'h50, 8'h10, 8'h6f},
      '{8'h00, 8'h00, 8'h00, 8'h00}
   };

   // Multiples of each digit weight, most significant digit first.
   localparam logic [13:0] DIGIT_MULT [DIGIT_COUNT][10] = '{
      '{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
        14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000},
      '{14'd0, 14'd100, 14'd200, 14'd300, 14'd400,
        14'd500, 14'd600, 14'd700, 14'd800, 14'd900},
      '{14'd0, 14'd10, 14'd20, 14'd30, 14'd40,
        14'd50, 14'd60, 14'd70, 14'd80, 14'd90},
      '{14'd0, 14'd1, 14'd2, 14'd3, 14'd4,
        14'd5, 14'd6, 14'd7, 14'd8, 14'd9}
   };

   // Request payload.
   typedef struct packed {
      logic [2:0]  command;
      logic        display_select;
      logic [13:0] value;
      logic        separator;
      logic [2:0]  word_index;
      logic [3:0]  brightness;
   } req_type;

   // Response payload: line levels after the transaction and status.
   typedef struct packed {
      logic clock_line_a;
      logic data_line_a;
      logic clock_line_b;
      logic data_line_b;
      logic busy_res;
      logic rejected;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ssd_channels.sv
// ============================================================================
// Display driver channels
// Valid/ready interfaces for the request and response channels.
// ============================================================================
`default_nettype none

interface ssd_req_if;
   logic            valid;
   logic            ready;
   ssd_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ssd_rsp_if;
   logic            valid;
   logic            ready;
   ssd_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/seven_segment_two_wire_display_driver.sv
// ============================================================================
// Seven-segment two-wire display driver
// Plays start, byte and stop sequences on the clock and data lines of two
// four-digit display chips, one microsecond unit per request transaction.
// ============================================================================
// Every request transaction is one time unit: a tick, or a command that
// loads a new sequence when the line sequencer is idle (and is reported as
// rejected otherwise). One transaction is taken per clock cycle while the
// skid register is empty; its result (line levels, busy, rejected) goes into
// the response register, or into a skid register while the response is
// stalled, which keeps the request side open for one more transaction. A
// show-decimal command fills its four digit bytes after acceptance, one
// digit per cycle from a compare-and-subtract converter; those bytes are
// first sent many transactions later. There is no clearing pass after reset.
`default_nettype none
`include "seven_segment_two_wire_display_driver_defines.svh"

module seven_segment_two_wire_display_driver (
   input  logic clock,
   input  logic reset,
   ssd_req_if.sink   req_chan,
   ssd_rsp_if.source rsp_chan
);
   import ssd_pkg::*;

   localparam logic MAX_SEL = 1'(DISPLAY_COUNT - 1);

   // Sequencer state.
   phase_type         phase_ff, phase_in;
   logic [2:0]        wait_ff, wait_in;
   logic [2:0]        bit_ff, bit_in;
   logic [POS_W-1:0]  byte_ff, byte_in;
   logic              target_ff, target_in;
   logic [3:0]        lines_ff, lines_in;
   seg_type           buf_ff [BYTE_COUNT];

   // Digit converter state.
   logic              dig_busy_ff;
   logic [STEP_W-1:0] dig_step_ff;
   logic [13:0]       dig_rem_ff;
   logic              dig_sep_ff;

   // Output stage.
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   logic              skid_valid_ff;
   rsp_type           skid_data_ff;

   logic              req_fire;
   logic              rsp_pop;
   cmd_type           cmd_c;
   logic              is_cmd;
   logic              accept_cmd;
   logic              rejected_c;
   logic              enter_en;
   phase_type         enter_ph;
   seg_type           rd_byte;
   rsp_type           result_c;
   logic [13:0]       value_wrapped;
   logic [2:0]        word_sel;
   logic [3:0]        bright_sel;
   logic [3:0]        dig_q;
   logic [13:0]       dig_rem_next;
   seg_type           dig_seg;
   logic [POS_W-1:0]  dig_idx;

   // Sets one line of the target display.
   function automatic logic [3:0] put_line(logic [3:0] lv, logic tgt, logic is_data,
                                           logic level);
      logic [1:0] sh;
      sh     = {tgt, is_data};
      lv[sh] = level;
      return lv;
   endfunction

   // Handshake.
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign rsp_pop          = rsp_valid_ff && rsp_chan.ready;
   assign req_chan.ready   = !skid_valid_ff;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Command decode and operand conditioning.
   assign cmd_c  = cmd_type'(req_chan.payload.command);
   assign is_cmd = (cmd_c == CMD_DECIMAL) || (cmd_c == CMD_TEXT) ||
                   (cmd_c == CMD_CLEAR) || (cmd_c == CMD_BRIGHT);
   assign accept_cmd = req_fire && is_cmd && (phase_ff == PH_IDLE);
   assign value_wrapped = (req_chan.payload.value >= VALUE_WRAP)
                        ? req_chan.payload.value - VALUE_WRAP : req_chan.payload.value;
   assign word_sel   = (req_chan.payload.word_index > 3'(WORD_COUNT - 1))
                     ? 3'(WORD_COUNT - 1) : req_chan.payload.word_index;
   assign bright_sel = (req_chan.payload.brightness > BRIGHT_MAX)
                     ? BRIGHT_MAX : req_chan.payload.brightness;

   // Line sequencer: one time unit per transaction, then the entry actions.
   always_comb begin
      phase_in   = phase_ff;
      wait_in    = wait_ff;
      bit_in     = bit_ff;
      byte_in    = byte_ff;
      target_in  = target_ff;
      lines_in   = lines_ff;
      rejected_c = 1'b0;
      enter_en   = 1'b0;
      enter_ph   = PH_IDLE;
      rd_byte    = '0;

      if (accept_cmd) begin
         target_in = (req_chan.payload.display_select > MAX_SEL)
                   ? MAX_SEL : req_chan.payload.display_select;
         byte_in   = (cmd_c == CMD_BRIGHT) ? POS_W'(LAST_BYTE) : '0;
         bit_in    = '0;
         enter_en  = 1'b1;
         enter_ph  = PH_START;
      end else if (req_fire && phase_ff != PH_IDLE) begin
         rejected_c = is_cmd;
         if (wait_ff > 3'd1) begin
            wait_in = wait_ff - 3'd1;
         end else begin
            wait_in = '0;
            case (phase_ff)
               PH_START: begin
                  lines_in = put_line(lines_in, target_in, 1'b1, 1'b0);
                  bit_in   = '0;
                  enter_en = 1'b1;
                  enter_ph = PH_BIT_LOW;
               end
               PH_BIT_LOW: begin
                  enter_en = 1'b1;
                  enter_ph = PH_BIT_HIGH;
               end
               PH_BIT_HIGH: begin
                  enter_en = 1'b1;
                  if (bit_ff < 3'd7) begin
                     bit_in   = bit_ff + 3'd1;
                     enter_ph = PH_BIT_LOW;
                  end else begin
                     enter_ph = PH_ACK_LOW;
                  end
               end
               PH_ACK_LOW: begin
                  enter_en = 1'b1;
                  enter_ph = PH_ACK_HIGH;
               end
               PH_ACK_HIGH: begin
                  lines_in = put_line(lines_in, target_in, 1'b0, 1'b0);
                  enter_en = 1'b1;
                  if (byte_ff == '0 || byte_ff >= POS_W'(LAST_BYTE)) begin
                     enter_ph = PH_STOP_A;
                  end else begin
                     byte_in  = byte_ff + POS_W'(1);
                     bit_in   = '0;
                     enter_ph = PH_BIT_LOW;
                  end
               end
               PH_STOP_A: begin
                  enter_en = 1'b1;
                  enter_ph = PH_STOP_B;
               end
               PH_STOP_B: begin
                  enter_en = 1'b1;
                  enter_ph = PH_STOP_C;
               end
               PH_STOP_C: begin
                  lines_in = put_line(lines_in, target_in, 1'b1, 1'b1);
                  if (byte_ff == '0) begin
                     byte_in  = POS_W'(1);
                     enter_en = 1'b1;
                     enter_ph = PH_START;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end

      // Entry actions of the new phase.
      if (enter_en) begin
         phase_in = enter_ph;
         case (enter_ph)
            PH_START: begin
               lines_in = put_line(lines_in, target_in, 1'b0, 1'b1);
               lines_in = put_line(lines_in, target_in, 1'b1, 1'b1);
               wait_in  = WAIT_START;
            end
            PH_BIT_LOW: begin
               if (byte_in < POS_W'(BYTE_COUNT)) begin
                  rd_byte = buf_ff[byte_in];
               end
               lines_in = put_line(lines_in, target_in, 1'b0, 1'b0);
               lines_in = put_line(lines_in, target_in, 1'b1, rd_byte[bit_in]);
               wait_in  = WAIT_BIT;
            end
            PH_BIT_HIGH: begin
               lines_in = put_line(lines_in, target_in, 1'b0, 1'b1);
               wait_in  = WAIT_BIT;
            end
            PH_ACK_LOW: begin
               lines_in = put_line(lines_in, target_in, 1'b0, 1'b0);
               wait_in  = WAIT_ACK_L;
            end
            PH_ACK_HIGH: begin
               lines_in = put_line(lines_in, target_in, 1'b0, 1'b1);
               wait_in  = WAIT_SHORT;
            end
            PH_STOP_A: begin
               lines_in = put_line(lines_in, target_in, 1'b0, 1'b0);
               wait_in  = WAIT_SHORT;
            end
            PH_STOP_B: begin
               lines_in = put_line(lines_in, target_in, 1'b1, 1'b0);
               wait_in  = WAIT_SHORT;
            end
            PH_STOP_C: begin
               lines_in = put_line(lines_in, target_in, 1'b0, 1'b1);
               wait_in  = WAIT_SHORT;
            end
            default: begin
               phase_in = PH_IDLE;
               wait_in  = '0;
            end
         endcase
      end
   end

   // Result of this transaction.
   always_comb begin
      result_c.clock_line_a = lines_in[0];
      result_c.data_line_a  = lines_in[1];
      result_c.clock_line_b = lines_in[2];
      result_c.data_line_b  = lines_in[3];
      result_c.busy_res     = (phase_in != PH_IDLE);
      result_c.rejected     = rejected_c;
   end

   // Digit converter: one decimal digit per cycle, most significant first.
   always_comb begin
      dig_q = '0;
      for (int m = 1; m < 10; m++) begin
         if (dig_rem_ff >= DIGIT_MULT[dig_step_ff][m]) begin
            dig_q = 4'(m);
         end
      end
      dig_rem_next = dig_rem_ff - DIGIT_MULT[dig_step_ff][dig_q];
      dig_seg      = DIGIT_SEGS[dig_q];
      if (dig_sep_ff && dig_step_ff == STEP_W'(1)) begin
         dig_seg = dig_seg | SEP_MASK;
      end
      dig_idx = POS_W'(2) + POS_W'(dig_step_ff);
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         wait_ff   <= '0;
         bit_ff    <= '0;
         byte_ff   <= '0;
         target_ff <= 1'b0;
         lines_ff  <= 4'hF;
      end else begin
         phase_ff  <= phase_in;
         wait_ff   <= wait_in;
         bit_ff    <= bit_in;
         byte_ff   <= byte_in;
         target_ff <= target_in;
         lines_ff  <= lines_in;
      end
   end

   // Digit converter control.
   always_ff @(posedge clock) begin
      if (reset) begin
         dig_busy_ff <= 1'b0;
      end else if (accept_cmd) begin
         dig_busy_ff <= (cmd_c == CMD_DECIMAL);
      end else if (dig_busy_ff && dig_step_ff == STEP_W'(DIGIT_COUNT - 1)) begin
         dig_busy_ff <= 1'b0;
      end
   end

   // Byte buffer and converter data; a new command overrides the converter.
   always_ff @(posedge clock) begin
      if (dig_busy_ff) begin
         buf_ff[dig_idx] <= dig_seg;
         dig_rem_ff      <= dig_rem_next;
         dig_step_ff     <= dig_step_ff + STEP_W'(1);
      end
      if (accept_cmd) begin
         case (cmd_c)
            CMD_BRIGHT: begin
               buf_ff[LAST_BYTE] <= BRIGHT_BASE + 8'(bright_sel);
            end
            CMD_DECIMAL: begin
               buf_ff[0]   <= MODE_BYTE;
               buf_ff[1]   <= ADDR_BYTE;
               dig_rem_ff  <= value_wrapped;
               dig_step_ff <= '0;
               dig_sep_ff  <= req_chan.payload.separator;
            end
            CMD_TEXT: begin
               buf_ff[0] <= MODE_BYTE;
               buf_ff[1] <= ADDR_BYTE;
               for (int i = 0; i < DIGIT_COUNT; i++) begin
                  buf_ff[2 + i] <= WORD_SEGS[word_sel][i];
               end
            end
            default: begin
               buf_ff[0] <= MODE_BYTE;
               buf_ff[1] <= ADDR_BYTE;
               for (int i = 0; i < DIGIT_COUNT; i++) begin
                  buf_ff[2 + i] <= '0;
               end
            end
         endcase
      end
   end

   // Response register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= req_fire;
         end
      end else if (req_fire) begin
         if (rsp_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_pop && skid_valid_ff) begin
         rsp_data_ff <= skid_data_ff;
      end else if (req_fire && (rsp_pop || !rsp_valid_ff)) begin
         rsp_data_ff <= result_c;
      end else if (req_fire) begin
         skid_data_ff <= result_c;
      end
   end

   // A full skid register always has a transaction ahead of it.
   `SSD_ASSERT_IMPL(a_skid_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff)
   // A skid transaction is kept until the response register frees.
   `SSD_ASSERT_NEXT(a_skid_held, clock, reset, skid_valid_ff && !rsp_pop, skid_valid_ff)
   // An idle sequencer has no hold time left.
   `SSD_ASSERT_IMPL(a_idle_no_wait, clock, reset, phase_ff == PH_IDLE, wait_ff == '0)
   // While display a is addressed, the lines of display b stay high.
   `SSD_ASSERT_IMPL(a_other_lines_high, clock, reset, target_ff == 1'b0, lines_ff[3:2] == 2'b11)
   // A show-decimal command starts the converter and the start phase.
   `SSD_ASSERT_NEXT(a_decimal_start, clock, reset, accept_cmd && cmd_c == CMD_DECIMAL, dig_busy_ff && phase_ff == PH_START)

endmodule

`default_nettype wire

FILE: test/seven_segment_two_wire_display_driver_checker.sv
// ----------------------------------------------------------------------------
// Line sequence checker for the seven-segment two-wire display driver
// Watches the request and response channels, predicts the line levels and
// status of every request transaction, and compares each response with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module seven_segment_two_wire_display_driver_checker (
   input  logic clock,
   input  logic reset,
   ssd_req_if   req_mon,
   ssd_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output logic line_busy
);
   import ssd_pkg::*;

   // Protocol bytes and segment patterns, kept independent of the design.
   localparam seg_type DISPLAY_MODE = 8'h40;
   localparam seg_type DIGIT_ADDR   = 8'hc0;
   localparam seg_type LEVEL_BASE   = 8'h87;
   localparam seg_type DOT_BIT      = 8'h80;
   localparam int      FINAL_BYTE   = 5;
   localparam int      BLANK_WORD   = 4;

   localparam seg_type NUMERAL_PATTERN [10] = '{
      8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
   };

   localparam seg_type LETTER_PATTERN [5][4] = '{
      '{8'h6d, 8'h78, 8'h77, 8'h50},
      '{8'h78, 8'h10, 8'h54, 8'h44},
      '{8'h7c, 8'h5c, 8'h54, 8'h1c},
      '{8'h7c, 8'h50, 8'h10, 8'h6f},
      '{8'h00, 8'h00, 8'h00, 8'h00}
   };

   // Mirror of the line sequencer.
   phase_type  seq_phase;
   seg_type    frame_bytes [6];
   int         byte_idx;
   int         bit_idx;
   int         hold_left;
   int         target_disp;
   logic [3:0] line_lvl;

   rsp_type expected_lines [$];
   rsp_type got_lines;
   rsp_type want_lines;
   int      rsp_index;

   // Drive one line of the targeted display; bit order is clock a, data a,
   // clock b, data b.
   function automatic void drive_line(bit is_data, bit level);
      line_lvl[target_disp * 2 + int'(is_data)] = level;
   endfunction

   // Enter a phase: apply its line changes and load its hold time.
   function automatic void enter_phase(phase_type p);
      seg_type cur;
      seq_phase = p;
      case (p)
         PH_START: begin
            drive_line(0, 1);
            drive_line(1, 1);
            hold_left = 2;
         end
         PH_BIT_LOW: begin
            cur = frame_bytes[byte_idx];
            drive_line(0, 0);
            drive_line(1, cur[bit_idx]);
            hold_left = 3;
         end
         PH_BIT_HIGH: begin
            drive_line(0, 1);
            hold_left = 3;
         end
         PH_ACK_LOW: begin
            drive_line(0, 0);
            hold_left = 5;
         end
         PH_ACK_HIGH: begin
            drive_line(0, 1);
            hold_left = 2;
         end
         PH_STOP_A: begin
            drive_line(0, 0);
            hold_left = 2;
         end
         PH_STOP_B: begin
            drive_line(1, 0);
            hold_left = 2;
         end
         PH_STOP_C: begin
            drive_line(0, 1);
            hold_left = 2;
         end
         default: begin
            seq_phase = PH_IDLE;
            hold_left = 0;
         end
      endcase
   endfunction

   // Spend one microsecond unit of the running sequence.
   function automatic void step_sequencer();
      if (seq_phase == PH_IDLE) return;
      if (hold_left > 1) begin
         hold_left--;
         return;
      end
      hold_left = 0;
      case (seq_phase)
         PH_START: begin
            drive_line(1, 0);
            bit_idx = 0;
            enter_phase(PH_BIT_LOW);
         end
         PH_BIT_LOW: enter_phase(PH_BIT_HIGH);
         PH_BIT_HIGH: begin
            if (bit_idx < 7) begin
               bit_idx++;
               enter_phase(PH_BIT_LOW);
            end else begin
               enter_phase(PH_ACK_LOW);
            end
         end
         PH_ACK_LOW: enter_phase(PH_ACK_HIGH);
         PH_ACK_HIGH: begin
            drive_line(0, 0);
            // The mode frame and the brightness frame carry a single byte.
            if (byte_idx == 0 || byte_idx >= FINAL_BYTE) begin
               enter_phase(PH_STOP_A);
            end else begin
               byte_idx++;
               bit_idx = 0;
               enter_phase(PH_BIT_LOW);
            end
         end
         PH_STOP_A: enter_phase(PH_STOP_B);
         PH_STOP_B: enter_phase(PH_STOP_C);
         PH_STOP_C: begin
            drive_line(1, 1);
            // After the mode frame the address and digit frame follows.
            if (byte_idx == 0) begin
               byte_idx = 1;
               enter_phase(PH_START);
            end else begin
               seq_phase = PH_IDLE;
            end
         end
         default: seq_phase = PH_IDLE;
      endcase
   endfunction

   // Work out the line levels and status after one request transaction.
   function automatic rsp_type predict_lines(req_type item);
      rsp_type    res;
      logic [2:0] code;
      bit         is_command;
      int         num;
      int         digit;
      int         word;
      int         level;
      seg_type    pattern;
      code = item.command;
      is_command = (code >= CMD_DECIMAL) && (code <= CMD_BRIGHT);
      res.rejected = 1'b0;
      if (is_command && seq_phase != PH_IDLE) begin
         // A command while a sequence runs is dropped but still spends a unit.
         res.rejected = 1'b1;
         step_sequencer();
      end else if (is_command) begin
         target_disp = (int'(item.display_select) > DISPLAY_COUNT - 1) ?
                       DISPLAY_COUNT - 1 : int'(item.display_select);
         if (code == CMD_BRIGHT) begin
            level = (item.brightness > 4'd8) ? 8 : int'(item.brightness);
            frame_bytes[FINAL_BYTE] = LEVEL_BASE + seg_type'(level);
            byte_idx = FINAL_BYTE;
         end else begin
            frame_bytes[0] = DISPLAY_MODE;
            frame_bytes[1] = DIGIT_ADDR;
            num = int'(item.value) % 10000;
            word = (item.word_index > 3'(BLANK_WORD)) ? BLANK_WORD : int'(item.word_index);
            for (int i = 0; i < 4; i++) begin
               if (code == CMD_DECIMAL) begin
                  case (i)
                     0: digit = num / 1000;
                     1: digit = (num / 100) % 10;
                     2: digit = (num / 10) % 10;
                     default: digit = num % 10;
                  endcase
                  pattern = NUMERAL_PATTERN[digit];
                  if (i == 1 && item.separator) pattern = pattern | DOT_BIT;
               end else if (code == CMD_TEXT) begin
                  pattern = LETTER_PATTERN[word][i];
               end else begin
                  pattern = 8'h00;
               end
               frame_bytes[2 + i] = pattern;
            end
            byte_idx = 0;
         end
         bit_idx = 0;
         enter_phase(PH_START);
      end else begin
         // Ticks and the unused command codes only spend a unit.
         step_sequencer();
      end
      res.clock_line_a = line_lvl[0];
      res.data_line_a  = line_lvl[1];
      res.clock_line_b = line_lvl[2];
      res.data_line_b  = line_lvl[3];
      res.busy_res     = (seq_phase != PH_IDLE);
      return res;
   endfunction

   // Check responses first, then predict the request accepted at this edge;
   // a response never belongs to a request of the same edge.
   always @(posedge clock) begin
      if (reset) begin
         seq_phase = PH_IDLE;
         foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
         byte_idx = 0;
         bit_idx = 0;
         hold_left = 0;
         target_disp = 0;
         line_lvl = 4'hf;
         expected_lines.delete();
         fail_count = 0;
         rsp_index = 0;
         pending = 0;
         line_busy = 1'b0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_lines = rsp_mon.payload;
            if (expected_lines.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("[checker] response %0d arrived with nothing expected", rsp_index);
            end else begin
               want_lines = expected_lines.pop_front();
               if (got_lines.clock_line_a !== want_lines.clock_line_a ||
                   got_lines.data_line_a  !== want_lines.data_line_a  ||
                   got_lines.clock_line_b !== want_lines.clock_line_b ||
                   got_lines.data_line_b  !== want_lines.data_line_b  ||
                   got_lines.busy_res     !== want_lines.busy_res     ||
                   got_lines.rejected     !== want_lines.rejected) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"[checker] response %0d: expected clk_a=%b dat_a=%b ",
                               "clk_b=%b dat_b=%b busy=%b rej=%b, got clk_a=%b dat_a=%b ",
                               "clk_b=%b dat_b=%b busy=%b rej=%b"}, rsp_index,
                              want_lines.clock_line_a, want_lines.data_line_a,
                              want_lines.clock_line_b, want_lines.data_line_b,
                              want_lines.busy_res, want_lines.rejected,
                              got_lines.clock_line_a, got_lines.data_line_a,
                              got_lines.clock_line_b, got_lines.data_line_b,
                              got_lines.busy_res, got_lines.rejected);
               end
            end
            rsp_index++;
         end
         if (req_mon.valid && req_mon.ready)
            expected_lines.push_back(predict_lines(req_mon.payload));
         pending = expected_lines.size();
         line_busy = (seq_phase != PH_IDLE);
      end
   end

endmodule

FILE: test/seven_segment_two_wire_display_driver_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the seven-segment two-wire display driver
// Sends directed and random display commands, each followed by mostly tick
// transactions until its line sequence ends, under random sender bursts and
// receiver stalls; the checker beside the design compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module seven_segment_two_wire_display_driver_tb;
   import ssd_pkg::*;

   localparam int         CYCLE_LIMIT  = 500000;
   localparam int         TOTAL_ITEMS  = 1250;
   localparam logic [2:0] CMD_CODE_TOP = 3'b111;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   logic line_busy;
   int   cycle_count;
   int   items_sent;
   int   burst_left;

   ssd_req_if req_chan ();
   ssd_rsp_if rsp_chan ();

   seven_segment_two_wire_display_driver uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   seven_segment_two_wire_display_driver_checker line_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending),
      .line_busy  (line_busy)
   );

   // Clock with an 8 ns period.
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Cycle counter and run limit.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[seven_segment_two_wire_display_driver] ERROR");
      $finish;
   end

   // Random content in every field.
   function automatic req_type scramble();
      req_type item;
      item.command        = 3'($urandom);
      item.display_select = 1'($urandom);
      item.value          = 14'($urandom);
      item.separator      = 1'($urandom);
      item.word_index     = 3'($urandom);
      item.brightness     = 4'($urandom);
      return item;
   endfunction

   function automatic req_type make_command(logic [2:0] code, bit sel, int num,
                                            bit sep, int word, int level);
      req_type item;
      item = scramble();
      item.command        = code;
      item.display_select = sel;
      item.value          = 14'(num);
      item.separator      = sep;
      item.word_index     = 3'(word);
      item.brightness     = 4'(level);
      return item;
   endfunction

   // Transaction offered while a sequence runs: mostly ticks, now and then an
   // unused code or a command that must be rejected.
   function automatic req_type filler_item();
      req_type item;
      int      pick;
      item = scramble();
      pick = $urandom_range(0, 15);
      if (pick == 0)
         item.command = 3'($urandom_range(CMD_DECIMAL, CMD_BRIGHT));
      else if (pick < 4)
         item.command = 3'($urandom_range(CMD_BRIGHT + 1, CMD_CODE_TOP));
      else
         item.command = CMD_TICK;
      return item;
   endfunction

   // Move to the next falling edge where an item may be offered, inserting
   // a random gap when the current burst is used up.
   task automatic next_slot();
      @(negedge clock);
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   // Offer one item at the current falling edge and wait for its acceptance.
   task automatic offer(input req_type item);
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   // Start a command from idle and tick until its line sequence has ended.
   task automatic play_command(input req_type item);
      offer(item);
      next_slot();
      while (line_busy) begin
         offer(filler_item());
         next_slot();
      end
   endtask

   // Hold the sender until every expected response has come back.
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   // Receiver: changing stall patterns, with a long hold-off from time to time.
   initial begin
      int mode;
      int stretch;
      int ready_cycles;
      int next_hold;
      int hold_left;
      ready_cycles = 0;
      next_hold = 400;
      hold_left = 0;
      wait (!reset);
      forever begin
         mode = $urandom_range(0, 3);
         stretch = $urandom_range(8, 60);
         repeat (stretch) begin
            @(negedge clock);
            ready_cycles++;
            if (ready_cycles >= next_hold) begin
               hold_left = 64;
               next_hold = next_hold + $urandom_range(1500, 4000);
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_chan.ready <= 1'b0;
            end else begin
               case (mode)
                  0: rsp_chan.ready <= 1'b1;
                  1: rsp_chan.ready <= 1'($urandom);
                  2: rsp_chan.ready <= (ready_cycles % 3) != 0;
                  default: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
               endcase
            end
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      req_type item;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      items_sent = 0;
      burst_left = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      next_slot();

      // Directed part: a value above 9999 that wraps, with the separator.
      play_command(make_command(CMD_DECIMAL, 0, 16383, 1, 0, 0));
      // A word index above the table shows blank.
      play_command(make_command(CMD_TEXT, 1, 0, 0, 6, 0));
      // Brightness clamped from above the range, and off.
      play_command(make_command(CMD_BRIGHT, 0, 0, 0, 0, 15));
      play_command(make_command(CMD_BRIGHT, 1, 0, 0, 0, 0));
      // Unused codes while idle behave as ticks.
      for (int c = CMD_BRIGHT + 1; c <= CMD_CODE_TOP; c++) begin
         offer(make_command(3'(c), 1'(c), 5678, 1, 1, 3));
         next_slot();
      end
      drain();

      // Random part: mostly complete command sequences, a few idle ticks.
      next_slot();
      while (items_sent < TOTAL_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               item = filler_item();
               if (item.command >= CMD_DECIMAL && item.command <= CMD_BRIGHT)
                  item.command = CMD_TICK;
               offer(item);
               next_slot();
            end
         end else begin
            item = scramble();
            item.command = 3'($urandom_range(CMD_DECIMAL, CMD_BRIGHT));
            play_command(item);
         end
      end

      // Let the last responses come back, then allow the pipeline to settle.
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (24) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("[seven_segment_two_wire_display_driver] OK");
      else
         $display("[seven_segment_two_wire_display_driver] ERROR");
      $finish;
   end

endmodule
